>>> src/bear_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bear_pkg
// Shared constants, register map and types of the button edge and repeat block.
// ----------------------------------------------------------------------------
package bear_pkg;

  localparam int PLAIN_BUTTONS = 12;
  localparam int ALL_BUTTONS   = 16;
  localparam int DIR_LANES     = 4;
  localparam int PERIOD_W      = 8;
  localparam int AXIS_W        = 16;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [1:0] REG_REPEAT_PERIOD  = 2'd0;
  localparam logic [1:0] REG_THRESHOLD_HIGH = 2'd1;
  localparam logic [1:0] REG_THRESHOLD_LOW  = 2'd2;

  localparam logic [PERIOD_W-1:0] RESET_REPEAT_PERIOD  = PERIOD_W'(10);
  localparam logic [AXIS_W-1:0]   RESET_THRESHOLD_HIGH = AXIS_W'(49152);
  localparam logic [AXIS_W-1:0]   RESET_THRESHOLD_LOW  = AXIS_W'(16384);

  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  typedef struct packed {
    logic held;
    logic pressed;
    logic released;
    logic rep;
  } lane_flags_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] repeat_period;
    logic [AXIS_W-1:0]   threshold_high;
    logic [AXIS_W-1:0]   threshold_low;
  } cfg_t;

endpackage

>>> src/bear_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bear_sample_if / bear_result_if
// Valid/ready channels for poll sample words and result words.
// ----------------------------------------------------------------------------
interface bear_sample_if;
  import bear_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     sample_valid;
  logic [PLAIN_BUTTONS-1:0] button_bits;
  logic [AXIS_W-1:0]        x_position;
  logic [AXIS_W-1:0]        y_position;

  modport source (output valid, sample_valid, button_bits, x_position, y_position,
                  input ready);
  modport sink   (input valid, sample_valid, button_bits, x_position, y_position,
                  output ready);
endinterface

interface bear_result_if;
  import bear_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ALL_BUTTONS-1:0] held_bits;
  logic [ALL_BUTTONS-1:0] pressed_edge_bits;
  logic [ALL_BUTTONS-1:0] released_edge_bits;
  logic [ALL_BUTTONS-1:0] repeat_bits;

  modport source (output valid, held_bits, pressed_edge_bits, released_edge_bits,
                  repeat_bits, input ready);
  modport sink   (input valid, held_bits, pressed_edge_bits, released_edge_bits,
                  repeat_bits, output ready);
endinterface

>>> src/bear_levels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bear_levels
// Build the per-lane button levels from plain bits and axis threshold compares.
// ----------------------------------------------------------------------------
module bear_levels (
  input  logic [bear_pkg::PLAIN_BUTTONS-1:0] button_bits,
  input  logic [bear_pkg::AXIS_W-1:0]        x_position,
  input  logic [bear_pkg::AXIS_W-1:0]        y_position,
  input  bear_pkg::cfg_t                     cfg,
  output logic [bear_pkg::ALL_BUTTONS-1:0]   levels
);
  import bear_pkg::*;

  logic [DIR_LANES-1:0] dir;

  always_comb begin
    dir            = '0;
    dir[DIR_UP]    = y_position > cfg.threshold_high;
    dir[DIR_DOWN]  = y_position < cfg.threshold_low;
    dir[DIR_LEFT]  = x_position > cfg.threshold_high;
    dir[DIR_RIGHT] = x_position < cfg.threshold_low;
  end

  for (genvar i = 0; i < ALL_BUTTONS; i++) begin : g_lvl
    if (i < PLAIN_BUTTONS) begin : g_plain
      assign levels[i] = button_bits[i];
    end else if (i < PLAIN_BUTTONS + DIR_LANES) begin : g_dir
      assign levels[i] = dir[i-PLAIN_BUTTONS];
    end else begin : g_none
      assign levels[i] = 1'b0;
    end
  end

endmodule

>>> src/bear_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bear_lane
// One button lane: previous level, edge flags and the auto-repeat countdown.
// ----------------------------------------------------------------------------
module bear_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          level,
  input  logic [bear_pkg::PERIOD_W-1:0] repeat_period,
  output bear_pkg::lane_flags_t         flags
);
  import bear_pkg::*;

  logic                prev;
  logic [PERIOD_W-1:0] countdown;
  logic [PERIOD_W-1:0] countdown_next;
  logic                fire;

  assign fire = level && (countdown <= PERIOD_W'(1));

  always_comb begin
    if (!level) begin
      countdown_next = '0;
    end else if (fire) begin
      countdown_next = repeat_period;
    end else begin
      countdown_next = countdown - PERIOD_W'(1);
    end
  end

  assign flags.held     = level;
  assign flags.pressed  = level & ~prev;
  assign flags.released = prev & ~level;
  assign flags.rep      = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= 1'b0;
      countdown <= '0;
    end else if (step) begin
      prev      <= level;
      countdown <= countdown_next;
    end
  end

endmodule

>>> src/bear_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bear_merge
// Gather lane flags into the four result words and hold them for the sink.
// ----------------------------------------------------------------------------
module bear_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  bear_pkg::lane_flags_t flags [bear_pkg::ALL_BUTTONS],
  output logic                  open,
  bear_result_if.source         result
);
  import bear_pkg::*;

  logic                   valid;
  logic [ALL_BUTTONS-1:0] held;
  logic [ALL_BUTTONS-1:0] pressed;
  logic [ALL_BUTTONS-1:0] released;
  logic [ALL_BUTTONS-1:0] rep;
  logic [ALL_BUTTONS-1:0] held_next;
  logic [ALL_BUTTONS-1:0] pressed_next;
  logic [ALL_BUTTONS-1:0] released_next;
  logic [ALL_BUTTONS-1:0] rep_next;

  always_comb begin
    for (int i = 0; i < ALL_BUTTONS; i++) begin
      held_next[i]     = flags[i].held;
      pressed_next[i]  = flags[i].pressed;
      released_next[i] = flags[i].released;
      rep_next[i]      = flags[i].rep;
    end
  end

  assign open = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held     <= held_next;
      pressed  <= pressed_next;
      released <= released_next;
      rep      <= rep_next;
    end
  end

  assign result.valid              = valid;
  assign result.held_bits          = held;
  assign result.pressed_edge_bits  = pressed;
  assign result.released_edge_bits = released;
  assign result.repeat_bits        = rep;

endmodule

>>> src/button_edge_and_auto_repeat_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_edge_and_auto_repeat_top
// Per-button held, edge and auto-repeat flags from polled button and axis words.
//
//   channel  dir  handshake           word
//   sample   in   valid/ready         sample_valid, button_bits, x/y_position
//   result   out  valid/ready         held, pressed, released, repeat bits
//   config   in   APB write/read      repeat_period, threshold_high/low
//
// One word per cycle unless a full result register stalls; a result appears in
// the cycle after its sample is taken, held in the single result register.
// A sample is taken while the result register is empty or being drained.
// Samples with sample_valid low are taken and give no result.
// Reset clears lane state and restores register defaults.
// ----------------------------------------------------------------------------
module button_edge_and_auto_repeat_top (
  input  logic                        clk,
  input  logic                        rst,
  bear_sample_if.sink                 sample,
  bear_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bear_pkg::ADDR_W-1:0] paddr,
  input  logic [bear_pkg::DATA_W-1:0] pwdata,
  output logic [bear_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import bear_pkg::*;

  cfg_t                   cfg;
  logic                   wr_en;
  logic [1:0]             reg_idx;
  logic [ALL_BUTTONS-1:0] levels;
  lane_flags_t            flags [ALL_BUTTONS];
  logic                   open;
  logic                   take;
  logic                   step;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_period  <= RESET_REPEAT_PERIOD;
      cfg.threshold_high <= RESET_THRESHOLD_HIGH;
      cfg.threshold_low  <= RESET_THRESHOLD_LOW;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_REPEAT_PERIOD:  cfg.repeat_period  <= pwdata[PERIOD_W-1:0];
        REG_THRESHOLD_HIGH: cfg.threshold_high <= pwdata[AXIS_W-1:0];
        REG_THRESHOLD_LOW:  cfg.threshold_low  <= pwdata[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REPEAT_PERIOD:  prdata = DATA_W'(cfg.repeat_period);
      REG_THRESHOLD_HIGH: prdata = DATA_W'(cfg.threshold_high);
      REG_THRESHOLD_LOW:  prdata = DATA_W'(cfg.threshold_low);
      default:            prdata = '0;
    endcase
  end

  assign sample.ready = open;
  assign take         = sample.valid && open;
  assign step         = take && sample.sample_valid;

  bear_levels u_levels (
    .button_bits (sample.button_bits),
    .x_position  (sample.x_position),
    .y_position  (sample.y_position),
    .cfg         (cfg),
    .levels      (levels)
  );

  for (genvar i = 0; i < ALL_BUTTONS; i++) begin : g_lane
    bear_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .step          (step),
      .level         (levels[i]),
      .repeat_period (cfg.repeat_period),
      .flags         (flags[i])
    );
  end

  bear_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .flags  (flags),
    .open   (open),
    .result (result)
  );

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> result.valid)
    else $error("valid sample did not produce a result");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.pressed_edge_bits & result.released_edge_bits) == '0)
    else $error("lane both pressed and released");

  a_pressed_held: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.pressed_edge_bits & ~result.held_bits) == '0)
    else $error("pressed edge on a lane not held");

  a_repeat_held: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.repeat_bits & ~result.held_bits) == '0)
    else $error("repeat on a lane not held");

  a_press_repeats: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.pressed_edge_bits & ~result.repeat_bits) == '0)
    else $error("new press did not fire repeat");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_edge_and_auto_repeat_top.
// Sends poll sample words over valid/ready and programs the repeat period and
// the axis thresholds over APB between phases. A lane model in the bench
// tracks levels, edges and repeat countdowns, and each result word is checked
// against it or, for fixed rows, the table. Directed table words come first,
// then random phases mixing sender idling, receiver stalls, one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import bear_pkg::*;

  localparam int LIMIT_CYCLES    = 300000;
  localparam int PHASE_WORDS     = 200;
  localparam int PHASES          = 6;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 4;
  localparam int DIRECTED_ROWS   = 12;

  typedef struct packed {
    logic                     sample_valid;
    logic [PLAIN_BUTTONS-1:0] buttons;
    logic [AXIS_W-1:0]        x;
    logic [AXIS_W-1:0]        y;
  } poll_word_t;

  typedef struct packed {
    logic [ALL_BUTTONS-1:0] held;
    logic [ALL_BUTTONS-1:0] pressed;
    logic [ALL_BUTTONS-1:0] released;
    logic [ALL_BUTTONS-1:0] rep;
  } flags_word_t;

  typedef struct packed {
    logic                     sv;
    logic [3:0]               count;
    logic [PLAIN_BUTTONS-1:0] buttons;
    logic [AXIS_W-1:0]        x;
    logic [AXIS_W-1:0]        y;
    logic                     fixed;
    logic [ALL_BUTTONS-1:0]   held;
    logic [ALL_BUTTONS-1:0]   pressed;
    logic [ALL_BUTTONS-1:0]   released;
    logic [ALL_BUTTONS-1:0]   rep;
  } stim_row_t;

  // register defaults, axes at center and at the thresholds, then a long hold
  localparam stim_row_t STIM [DIRECTED_ROWS] = '{
    '{1'b1, 4'd1,  12'h000, 16'd32768, 16'd32768, 1'b1,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{1'b1, 4'd1,  12'hFFF, 16'd0,     16'd0,     1'b1,
      16'hAFFF, 16'hAFFF, 16'h0000, 16'hAFFF},
    '{1'b0, 4'd1,  12'h5A5, 16'd65535, 16'd1234,  1'b0,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{1'b1, 4'd1,  12'h000, 16'd65535, 16'd65535, 1'b1,
      16'h5000, 16'h5000, 16'hAFFF, 16'h5000},
    '{1'b1, 4'd1,  12'h000, 16'd49152, 16'd49152, 1'b1,
      16'h0000, 16'h0000, 16'h5000, 16'h0000},
    '{1'b1, 4'd1,  12'h000, 16'd16384, 16'd16384, 1'b1,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{1'b1, 4'd1,  12'h000, 16'd16383, 16'd16383, 1'b1,
      16'hA000, 16'hA000, 16'h0000, 16'hA000},
    '{1'b1, 4'd1,  12'h000, 16'd49153, 16'd49153, 1'b1,
      16'h5000, 16'h5000, 16'hA000, 16'h5000},
    '{1'b1, 4'd12, 12'h001, 16'd32768, 16'd32768, 1'b0,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{1'b1, 4'd1,  12'h800, 16'd32768, 16'd0,     1'b0,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{1'b1, 4'd1,  12'hAAA, 16'd0,     16'd65535, 1'b0,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{1'b1, 4'd1,  12'h555, 16'd65535, 16'd0,     1'b0,
      16'h0000, 16'h0000, 16'h0000, 16'h0000}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bear_sample_if sample_ch ();
  bear_result_if result_ch ();

  button_edge_and_auto_repeat_top dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // lane model
  cfg_t                model_cfg;
  logic [ALL_BUTTONS-1:0] prior_levels;
  logic [PERIOD_W-1:0] lane_countdown [ALL_BUTTONS];

  flags_word_t expected_flags [$];
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;

  logic [PLAIN_BUTTONS-1:0] cur_buttons = '0;
  logic [AXIS_W-1:0]        cur_x = 16'd32768;
  logic [AXIS_W-1:0]        cur_y = 16'd32768;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[button_edge_and_auto_repeat_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_armed && !hold_done) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (hold_armed);
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_done <= 1'b1;
  end

  always @(posedge clk) begin
    flags_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_flags.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = expected_flags.pop_front();
        if (result_ch.held_bits !== want.held) begin
          $error("held_bits: expected %h, got %h", want.held, result_ch.held_bits);
          errors++;
        end
        if (result_ch.pressed_edge_bits !== want.pressed) begin
          $error("pressed_edge_bits: expected %h, got %h", want.pressed,
                 result_ch.pressed_edge_bits);
          errors++;
        end
        if (result_ch.released_edge_bits !== want.released) begin
          $error("released_edge_bits: expected %h, got %h", want.released,
                 result_ch.released_edge_bits);
          errors++;
        end
        if (result_ch.repeat_bits !== want.rep) begin
          $error("repeat_bits: expected %h, got %h", want.rep, result_ch.repeat_bits);
          errors++;
        end
      end
    end
  end

  function automatic flags_word_t advance_lanes(poll_word_t w);
    flags_word_t            f;
    logic [ALL_BUTTONS-1:0] lv;
    lv = '0;
    lv[PLAIN_BUTTONS-1:0] = w.buttons;
    lv[PLAIN_BUTTONS+DIR_UP]    = (w.y > model_cfg.threshold_high);
    lv[PLAIN_BUTTONS+DIR_DOWN]  = (w.y < model_cfg.threshold_low);
    lv[PLAIN_BUTTONS+DIR_LEFT]  = (w.x > model_cfg.threshold_high);
    lv[PLAIN_BUTTONS+DIR_RIGHT] = (w.x < model_cfg.threshold_low);
    f.rep = '0;
    for (int i = 0; i < ALL_BUTTONS; i++) begin
      if (lv[i]) begin
        if (lane_countdown[i] <= 1) begin
          f.rep[i] = 1'b1;
          lane_countdown[i] = model_cfg.repeat_period;
        end else begin
          lane_countdown[i] = lane_countdown[i] - 1'b1;
        end
      end else begin
        lane_countdown[i] = '0;
      end
    end
    f.held     = lv;
    f.pressed  = lv & ~prior_levels;
    f.released = prior_levels & ~lv;
    prior_levels = lv;
    return f;
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return model_cfg.threshold_high;
      3: return model_cfg.threshold_high + 1'b1;
      4: return model_cfg.threshold_low;
      5: return model_cfg.threshold_low - 1'b1;
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  task automatic send_word(poll_word_t w, bit fixed, flags_word_t want);
    flags_word_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_valid <= w.sample_valid;
    sample_ch.button_bits  <= w.buttons;
    sample_ch.x_position   <= w.x;
    sample_ch.y_position   <= w.y;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (w.sample_valid) begin
      predicted = advance_lanes(w);
      expected_flags.push_back(fixed ? want : predicted);
    end
  endtask

  task automatic apply_row(bit sv, logic [PLAIN_BUTTONS-1:0] b, logic [AXIS_W-1:0] x,
                           logic [AXIS_W-1:0] y, bit fixed,
                           logic [ALL_BUTTONS-1:0] held, logic [ALL_BUTTONS-1:0] pr,
                           logic [ALL_BUTTONS-1:0] rel, logic [ALL_BUTTONS-1:0] rep);
    poll_word_t  w;
    flags_word_t want;
    w.sample_valid = sv;
    w.buttons      = b;
    w.x            = x;
    w.y            = y;
    want.held      = held;
    want.pressed   = pr;
    want.released  = rel;
    want.rep       = rep;
    send_word(w, fixed, want);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_REPEAT_PERIOD:  model_cfg.repeat_period  = val[PERIOD_W-1:0];
      REG_THRESHOLD_HIGH: model_cfg.threshold_high = val[AXIS_W-1:0];
      REG_THRESHOLD_LOW:  model_cfg.threshold_low  = val[AXIS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_config(int period, int hi, int lo);
    write_reg(REG_REPEAT_PERIOD, DATA_W'(period));
    write_reg(REG_THRESHOLD_HIGH, DATA_W'(hi));
    write_reg(REG_THRESHOLD_LOW, DATA_W'(lo));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(int n);
    int         taken;
    poll_word_t w;
    taken = 0;
    while (taken < n) begin
      if ($urandom_range(99) < 8) begin
        w.sample_valid = 1'b0;
        w.buttons      = PLAIN_BUTTONS'($urandom);
        w.x            = AXIS_W'($urandom);
        w.y            = AXIS_W'($urandom);
      end else begin
        if ($urandom_range(99) < 3) cur_buttons = PLAIN_BUTTONS'($urandom);
        else if ($urandom_range(99) < 10)
          cur_buttons[$urandom_range(PLAIN_BUTTONS-1)] ^= 1'b1;
        if ($urandom_range(99) < 8) cur_x = pick_axis();
        if ($urandom_range(99) < 8) cur_y = pick_axis();
        w.sample_valid = 1'b1;
        w.buttons      = cur_buttons;
        w.x            = cur_x;
        w.y            = cur_y;
        taken++;
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    rst                    <= 1'b1;
    sample_ch.valid        <= 1'b0;
    sample_ch.sample_valid <= 1'b0;
    sample_ch.button_bits  <= '0;
    sample_ch.x_position   <= '0;
    sample_ch.y_position   <= '0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    model_cfg.repeat_period  = RESET_REPEAT_PERIOD;
    model_cfg.threshold_high = RESET_THRESHOLD_HIGH;
    model_cfg.threshold_low  = RESET_THRESHOLD_LOW;
    prior_levels = '0;
    for (int i = 0; i < ALL_BUTTONS; i++) lane_countdown[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      repeat (STIM[r].count) begin
        apply_row(STIM[r].sv, STIM[r].buttons, STIM[r].x, STIM[r].y, STIM[r].fixed,
                  STIM[r].held, STIM[r].pressed, STIM[r].released, STIM[r].rep);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          program_config(10, 49152, 16384);
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          program_config(1, 65535, 0);
          send_idle_pct = 79;
          recv_stall_pct <= 0;
        end
        2: begin
          program_config(255, 0, 65535);
          send_idle_pct = 0;
          recv_stall_pct <= 79;
        end
        3: begin
          program_config(0, 32768, 32768);
          send_idle_pct = 31;
          recv_stall_pct <= 31;
        end
        4: begin
          program_config(3, $urandom_range(65535), $urandom_range(65535));
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          hold_armed <= 1'b1;
        end
        default: begin
          program_config($urandom_range(1, 255), $urandom_range(65535),
                         $urandom_range(65535));
          send_idle_pct = 31;
          recv_stall_pct <= 31;
        end
      endcase
      run_random_phase(PHASE_WORDS);
    end

    settle();
    if (errors == 0) begin
      $display("[button_edge_and_auto_repeat_top] OK");
    end else begin
      $display("[button_edge_and_auto_repeat_top] ERROR");
    end
    $finish;
  end

endmodule
